// ----- src/assert_macros.svh -----
// Assertion macros used by the matcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Invariant that must hold on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

// ----- src/rdsm_pkg.sv -----
// Package: sizes, opcodes, pattern symbols and cell control for the matcher.
package rdsm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SYM_W       = 8;
  localparam int OP_W        = 2;

  localparam logic [SYM_W-1:0] SYM_ANY  = 8'h2E;
  localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic start;   // first text byte: seed from the empty-text column
    logic step;    // text byte accepted: take the new match bit
    logic clear;   // text abandoned: drop the match bit
    logic load;    // append lands in this cell
    logic active;  // cell index is below the pattern length
  } cell_ctl_t;

endpackage

// ----- src/rdsm_ifs.sv -----
// Interfaces: command channel and result channel.
interface rdsm_cmd_if;
  import rdsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [SYM_W-1:0] symbol;
  modport source (output valid, output opcode, output symbol, input ready);
  modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface rdsm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;
  modport source (output valid, output matched, output overflow, input ready);
  modport sink   (input valid, input matched, input overflow, output ready);
endinterface

// ----- src/rdsm_cell.sv -----
// One pattern cell: pattern byte, empty-text match bit and running match bit.
module rdsm_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  rdsm_pkg::cell_ctl_t      ctl,
  input  logic [rdsm_pkg::SYM_W-1:0] sym,
  input  logic                     prev_cur,     // column bit of left cell
  input  logic                     prev_fits,    // left cell byte fits sym
  input  logic                     prev2_next,   // new bit two cells left
  input  logic                     prev2_empty,  // empty-text bit two cells left
  output logic                     cur,
  output logic                     fits,
  output logic                     next_bit,
  output logic                     empty,
  output logic                     match
);
  import rdsm_pkg::*;

  logic [SYM_W-1:0] pat;
  logic             is_star;

  // pattern byte and its empty-text bit only change on append
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pat   <= sym;
      empty <= (sym == SYM_STAR) & prev2_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      match <= 1'b0;
    end else if (ctl.step) begin
      match <= next_bit;
    end
  end

  assign is_star  = (pat == SYM_STAR);
  assign fits     = (pat == SYM_ANY) || (pat == sym);
  assign cur      = ctl.active & (ctl.start ? empty : match);
  // byte step, or star: skip pair / repeat preceding byte
  assign next_bit = ctl.active &
                    ((fits & prev_cur) | (is_star & (prev2_next | (prev_fits & cur))));

endmodule

// ----- src/regex_dot_star_matcher_unit.sv -----
// Top level: command decode, chain of pattern cells and result register.
//
//  channel | dir | word                      | note
//  --------+-----+---------------------------+------------------------------
//  cmd     | in  | opcode[1:0], symbol[7:0]  | clear / append / text / finish
//  res     | out | matched, overflow         | one word per finish
//
// A new command word is taken each cycle while cmd.ready is high.
// A text byte updates all cells in that cycle; the only long path is the
// ripple of new match bits through runs of star cells.
// rst (synchronous) empties the pattern and clears the overflow, text and result-valid flags.
// cmd stalls only while a result word waits in the output register and
// res.ready is low.
`include "assert_macros.svh"

module regex_dot_star_matcher_unit (
  input logic        clk,
  input logic        rst,
  rdsm_cmd_if.sink   cmd,
  rdsm_res_if.source res
);
  import rdsm_pkg::*;

  logic [LEN_W-1:0] len;
  logic             overflowed;
  logic             text_started;
  logic             res_valid;
  logic             res_matched;
  logic             res_overflow;

  logic             cmd_acc;
  op_t              op;
  logic             do_clear, do_append, do_text, do_finish;
  logic             pat_full;

  cell_ctl_t        ctl [MAX_PATTERN];
  // column vectors, bit 0 is the virtual empty-pattern cell
  logic [MAX_PATTERN:0]   cur_col;
  logic [MAX_PATTERN:0]   fits_col;
  logic [MAX_PATTERN:0]   next_col;
  logic [MAX_PATTERN:0]   empty_col;
  logic [MAX_PATTERN-1:0] match_bits;
  logic                   final_bit;

  // output register parts the two sides
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign op        = op_t'(cmd.opcode);

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_text   = 1'b0;
    do_finish = 1'b0;
    unique case (op)
      OP_CLEAR:  do_clear  = cmd_acc;
      OP_APPEND: do_append = cmd_acc;
      OP_TEXT:   do_text   = cmd_acc;
      OP_FINISH: do_finish = cmd_acc;
      default:   do_clear  = 1'b0;
    endcase
  end

  assign pat_full = (len == LEN_W'(MAX_PATTERN));

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      overflowed   <= 1'b0;
      text_started <= 1'b0;
    end else begin
      if (do_clear) begin
        len        <= '0;
        overflowed <= 1'b0;
      end else if (do_append) begin
        if (pat_full) overflowed <= 1'b1;
        else          len        <= len + LEN_W'(1);
      end
      // anything but a text byte ends the text in progress
      if (do_text) text_started <= 1'b1;
      else if (cmd_acc) text_started <= 1'b0;
    end
  end

  // column seeds: bit 0 is set only while no text is in progress
  assign cur_col[0]   = !text_started;
  assign fits_col[0]  = 1'b0;
  assign next_col[0]  = 1'b0;
  assign empty_col[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic p2_next, p2_empty;

    always_comb begin
      ctl[k].start  = !text_started;
      ctl[k].step   = do_text;
      ctl[k].clear  = cmd_acc && !do_text;
      ctl[k].load   = do_append && (len == LEN_W'(k));
      ctl[k].active = (len > LEN_W'(k));
    end

    if (k == 0) begin : g_first
      // leading star matches empty; no pair to skip
      assign p2_next  = 1'b0;
      assign p2_empty = 1'b1;
    end else begin : g_rest
      assign p2_next  = next_col[k-1];
      assign p2_empty = empty_col[k-1];
    end

    rdsm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[k]),
      .sym         (cmd.symbol),
      .prev_cur    (cur_col[k]),
      .prev_fits   (fits_col[k]),
      .prev2_next  (p2_next),
      .prev2_empty (p2_empty),
      .cur         (cur_col[k+1]),
      .fits        (fits_col[k+1]),
      .next_bit    (next_col[k+1]),
      .empty       (empty_col[k+1]),
      .match       (match_bits[k])
    );
  end

  // bit of the full pattern in the column
  always_comb begin
    logic [LEN_W-1:0] last;
    last      = len - LEN_W'(1);
    final_bit = match_bits[last[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_finish) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      res_matched  <= text_started && (len != '0) && final_bit;
      res_overflow <= overflowed;
    end
  end

  assign res.valid    = res_valid;
  assign res.matched  = res_matched;
  assign res.overflow = res_overflow;

  // length is unknown until the first reset edge, so reset masks the check
  `ASSERT_ALWAYS(a_len_range, rst || (len <= LEN_W'(MAX_PATTERN)), "pattern length past capacity")
  `ASSERT_CLK(a_ovf_full, overflowed |-> pat_full, "overflow flag without full pattern")
  `ASSERT_CLK(a_finish_res, do_finish |=> (res_valid && !text_started), "finish lost its result")
  `ASSERT_CLK(a_text_seen, do_text |=> text_started, "text byte did not start text")

endmodule
